// ===== hw/rtl/ccs_pkg.sv =====
// Shared types, constants and round functions for the ChaCha stream cipher.
// Used by ccs_front, ccs_back and chacha_stream_cipher; no other dependencies.
package ccs_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int REM_W       = $clog2(BLOCK_BYTES) + 1;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_01    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_23    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_45    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_67    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTR_NONCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_256   = 3'd7;

    localparam logic [31:0] SIGMA0     = 32'h61707865;
    localparam logic [31:0] SIGMA1     = 32'h3320646e;
    localparam logic [31:0] SIGMA2     = 32'h79622d32;
    localparam logic [31:0] SIGMA3     = 32'h6b206574;
    localparam logic [31:0] TAU1       = 32'h3120646e;
    localparam logic [31:0] TAU2       = 32'h79622d36;

    typedef logic [15:0][31:0] words_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_t;

    function automatic logic [127:0] quarter(logic [31:0] a_i, logic [31:0] b_i,
                                             logic [31:0] c_i, logic [31:0] d_i);
        logic [31:0] a, b, c, d;
        a = a_i; b = b_i; c = c_i; d = d_i;
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

    // One column round, or one diagonal round when diag is set.
    function automatic words_t chacha_round(words_t w, logic diag);
        words_t       r;
        logic [127:0] q;
        int           ib, ic, id;
        r = w;
        for (int i = 0; i < 4; i++) begin
            ib = 4  + (diag ? ((i + 1) % 4) : i);
            ic = 8  + (diag ? ((i + 2) % 4) : i);
            id = 12 + (diag ? ((i + 3) % 4) : i);
            q = quarter(w[i], w[ib], w[ic], w[id]);
            r[i]  = q[127:96];
            r[ib] = q[95:64];
            r[ic] = q[63:32];
            r[id] = q[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/chacha_stream_cipher.sv =====
// Top level of the ChaCha stream cipher: input queue plus keystream back end.
// Depends on ccs_pkg, ccs_front and ccs_back.
//
// Usage: bytes enter on the s_ stream (tdata = data_in, tlast = end_of_message)
// and leave on the m_ stream (tdata = data_out, tlast = end_flag_out), one
// result per input byte, in order. Key, nonce, counter, round count and key
// size are written through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// A byte passes through the queue entry and then the output register while
// keystream is on hand. Keystream is made on demand, 64 bytes at a time: the
// first byte of each block waits for the round engine, which runs one round
// per cycle, and the next 63 bytes flow at one per cycle while bytes are queued
// and the receiver takes them. The two-entry input queue takes up to two
// bytes while the back end computes or the output waits; then s_tready drops.
// A stalled receiver holds the output register until it is taken.
// Reset (aresetn low at a clock edge) empties the queue and output, loads the
// default registers (20 rounds, 32-byte key) and discards keystream.
module chacha_stream_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);
    import ccs_pkg::*;

    item_t s_item, q_item, m_item;
    cfg_t  cfg;
    logic  q_valid, q_pop;

    assign s_item = '{last: s_tlast, data: s_tdata};
    assign cfg    = '{we: cfg_we, idx: cfg_addr, data: cfg_wdata};
    assign m_tdata = m_item.data;
    assign m_tlast = m_item.last;

    ccs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ccs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item)
    );

    // A result can only appear when the queue held a byte.
    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_valid))
        else $error("result without queued byte");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");
endmodule

// ===== hw/rtl/ccs_front.sv =====
// Input side of the ChaCha stream cipher: a two-entry queue of input bytes.
// Depends on ccs_pkg for the item type.
module ccs_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ccs_pkg::item_t s_item,
    output logic           q_valid,
    output ccs_pkg::item_t q_item,
    input  logic           q_pop
);
    import ccs_pkg::*;

    item_t      mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;

    always_comb begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ q_pop;
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end
endmodule

// ===== hw/rtl/ccs_back.sv =====
// Keystream side of the ChaCha stream cipher: configuration registers, round
// engine, keystream block store and output register. Depends on ccs_pkg.
module ccs_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  ccs_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  ccs_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output ccs_pkg::item_t m_item
);
    import ccs_pkg::*;

    typedef enum logic [2:0] {
        ST_SERVE = 3'b001,
        ST_ROUND = 3'b010,
        ST_ADD   = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [63:0]     key01_reg, key23_reg, key45_reg, key67_reg;
    logic [63:0]     ctr_nonce_reg, nonce_hi_reg;
    logic [4:0]      rounds_reg;
    logic            key256_reg;
    logic [31:0]     blk_ctr_reg, blk_ctr_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [5:0]      rnd_cnt_reg, rnd_cnt_next;
    words_t          work_reg, work_next;
    words_t          ks_reg, ks_next;
    words_t          init;
    logic            out_valid_reg, out_valid_next;
    item_t           out_item_reg, out_item_next;
    logic            out_free;
    logic [POS_W-1:0] pos;
    logic [5:0]      round_total;
    logic [31:0]     ks_word;
    logic [7:0]      ks_byte;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_item   = out_item_reg;
    assign pos      = POS_W'(REM_W'(BLOCK_BYTES) - rem_reg);
    assign ks_word  = ks_reg[pos[POS_W-1:2]];
    assign ks_byte  = ks_word[pos[1:0]*8 +: 8];
    // An odd round count is rounded up to the next even one (up to 32 rounds).
    assign round_total = (6'({1'b0, rounds_reg}) + 6'd1) & 6'h3E;

    always_comb begin
        init[0]  = SIGMA0;
        init[1]  = key256_reg ? SIGMA1 : TAU1;
        init[2]  = key256_reg ? SIGMA2 : TAU2;
        init[3]  = SIGMA3;
        init[4]  = key01_reg[31:0];
        init[5]  = key01_reg[63:32];
        init[6]  = key23_reg[31:0];
        init[7]  = key23_reg[63:32];
        init[8]  = key256_reg ? key45_reg[31:0]  : key01_reg[31:0];
        init[9]  = key256_reg ? key45_reg[63:32] : key01_reg[63:32];
        init[10] = key256_reg ? key67_reg[31:0]  : key23_reg[31:0];
        init[11] = key256_reg ? key67_reg[63:32] : key23_reg[63:32];
        init[12] = blk_ctr_reg;
        init[13] = ctr_nonce_reg[63:32];
        init[14] = nonce_hi_reg[31:0];
        init[15] = nonce_hi_reg[63:32];
    end

    always_comb begin
        state_next     = state_reg;
        blk_ctr_next   = blk_ctr_reg;
        rem_next       = rem_reg;
        rnd_cnt_next   = rnd_cnt_reg;
        work_next      = work_reg;
        ks_next        = ks_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_item_next  = out_item_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_SERVE: begin
                if (q_valid && out_free) begin
                    if (rem_reg == '0) begin
                        work_next    = init;
                        rnd_cnt_next = round_total;
                        state_next   = ST_ROUND;
                    end else begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_item_next  = '{last: q_item.last, data: q_item.data ^ ks_byte};
                        rem_next       = rem_reg - REM_W'(1);
                    end
                end
            end
            ST_ROUND: begin
                if (rnd_cnt_reg == '0) begin
                    state_next = ST_ADD;
                end else begin
                    // Even counts run a column round, odd counts a diagonal one.
                    work_next    = chacha_round(work_reg, rnd_cnt_reg[0]);
                    rnd_cnt_next = rnd_cnt_reg - 6'd1;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 16; i++) begin
                    ks_next[i] = work_reg[i] + init[i];
                end
                blk_ctr_next = blk_ctr_reg + 32'd1;
                rem_next     = REM_W'(BLOCK_BYTES);
                state_next   = ST_SERVE;
            end
            default: state_next = ST_SERVE;
        endcase
        // Writing the counter or nonce throws away what is left of the block.
        if (cfg.we && cfg.idx == REG_CTR_NONCE) begin
            blk_ctr_next = cfg.data[31:0];
            rem_next     = '0;
        end else if (cfg.we && cfg.idx == REG_NONCE_HI) begin
            rem_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        ks_reg       <= ks_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SERVE;
            key01_reg     <= '0;
            key23_reg     <= '0;
            key45_reg     <= '0;
            key67_reg     <= '0;
            ctr_nonce_reg <= '0;
            nonce_hi_reg  <= '0;
            rounds_reg    <= 5'd20;
            key256_reg    <= 1'b1;
            blk_ctr_reg   <= '0;
            rem_reg       <= '0;
            rnd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            blk_ctr_reg   <= blk_ctr_next;
            rem_reg       <= rem_next;
            rnd_cnt_reg   <= rnd_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.we) begin
                unique case (cfg.idx)
                    REG_KEY_01:    key01_reg     <= cfg.data;
                    REG_KEY_23:    key23_reg     <= cfg.data;
                    REG_KEY_45:    key45_reg     <= cfg.data;
                    REG_KEY_67:    key67_reg     <= cfg.data;
                    REG_CTR_NONCE: ctr_nonce_reg <= cfg.data;
                    REG_NONCE_HI:  nonce_hi_reg  <= cfg.data;
                    REG_ROUNDS:    rounds_reg    <= cfg.data[4:0];
                    REG_KEY_256:   key256_reg    <= cfg.data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== test/chacha_stream_cipher_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for chacha_stream_cipher: a byte stream is predicted
// with an in-bench ChaCha keystream generator. Depends on ccs_pkg and the RTL.
module chacha_stream_cipher_tb;
    import ccs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 1864;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_in
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] data_out
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    chacha_stream_cipher dut (.*);

    // Predictor copy of the registers and keystream state.
    logic [63:0] key_lo, key_mid, key_hi0, key_hi1, ctr_nonce, nonce_hi;
    logic [4:0]  rounds_reg;
    logic        wide_key;
    logic [31:0] ks_words [16];
    logic [31:0] blk_ctr;
    int          ks_left;

    item_t expected_bytes [$];
    int    mismatches;
    int    cycles;
    bit    rx_stall_mode;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         fixed;
        logic [7:0] want;
    } row_t;

    function automatic logic [31:0] rotl(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void qr(inout logic [31:0] w [16], input int a, int b, int c, int d);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    endfunction

    function automatic void refill_keystream();
        logic [31:0] init [16];
        logic [31:0] w [16];
        int          n_double;
        init[0] = SIGMA0; init[3] = SIGMA3;
        init[4] = key_lo[31:0];  init[5] = key_lo[63:32];
        init[6] = key_mid[31:0]; init[7] = key_mid[63:32];
        if (wide_key) begin
            init[1] = SIGMA1; init[2] = SIGMA2;
            init[8] = key_hi0[31:0];  init[9] = key_hi0[63:32];
            init[10] = key_hi1[31:0]; init[11] = key_hi1[63:32];
        end else begin
            init[1] = TAU1; init[2] = TAU2;
            for (int i = 8; i < 12; i++) init[i] = init[i - 4];
        end
        init[12] = blk_ctr;
        init[13] = ctr_nonce[63:32];
        init[14] = nonce_hi[31:0];
        init[15] = nonce_hi[63:32];
        w = init;
        n_double = (int'(rounds_reg) + 1) / 2;
        for (int r = 0; r < n_double; r++) begin
            qr(w, 0, 4, 8, 12); qr(w, 1, 5, 9, 13);
            qr(w, 2, 6, 10, 14); qr(w, 3, 7, 11, 15);
            qr(w, 0, 5, 10, 15); qr(w, 1, 6, 11, 12);
            qr(w, 2, 7, 8, 13); qr(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
        blk_ctr = blk_ctr + 1;
        ks_left = BLOCK_BYTES;
    endfunction

    function automatic logic [7:0] next_cipher_byte(logic [7:0] b);
        int pos;
        if (ks_left == 0) refill_keystream();
        pos = BLOCK_BYTES - ks_left;
        ks_left--;
        return b ^ ks_words[pos / 4][(pos % 4) * 8 +: 8];
    endfunction

    task automatic predict_reset();
        key_lo = '0; key_mid = '0; key_hi0 = '0; key_hi1 = '0;
        ctr_nonce = '0; nonce_hi = '0;
        rounds_reg = 5'd20; wide_key = 1'b1;
        blk_ctr = '0; ks_left = 0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall pattern alternates between free-running and random stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_stall_mode <= ~rx_stall_mode;
            m_tready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        item_t exp_b;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected transfer: %h/%b", m_tdata, m_tlast);
            end else begin
                exp_b = expected_bytes.pop_front();
                if (exp_b.data !== m_tdata || exp_b.last !== m_tlast) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 exp_b.data, exp_b.last, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY_01:    key_lo = val;
            REG_KEY_23:    key_mid = val;
            REG_KEY_45:    key_hi0 = val;
            REG_KEY_67:    key_hi1 = val;
            REG_CTR_NONCE: begin ctr_nonce = val; blk_ctr = val[31:0]; ks_left = 0; end
            REG_NONCE_HI:  begin nonce_hi = val; ks_left = 0; end
            REG_ROUNDS:    rounds_reg = val[4:0];
            REG_KEY_256:   wide_key = val[0];
            default: ;
        endcase
    endtask

    // Waits for all results, then lets the keystream engine settle.
    task automatic drain();
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // Sends one byte; s_tvalid stays high across back-to-back bytes in a burst.
    task automatic send_byte(logic [7:0] b, logic last);
        item_t it;
        s_tvalid <= 1'b1; s_tdata <= b; s_tlast <= last;
        it.data = next_cipher_byte(b);
        it.last = last;
        expected_bytes.push_back(it);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic random_config();
        write_reg(REG_KEY_01, {$urandom, $urandom});
        write_reg(REG_KEY_23, {$urandom, $urandom});
        write_reg(REG_KEY_45, {$urandom, $urandom});
        write_reg(REG_KEY_67, {$urandom, $urandom});
        write_reg(REG_NONCE_HI, {$urandom, $urandom});
        write_reg(REG_CTR_NONCE, {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 3)});
        write_reg(REG_ROUNDS, 64'($urandom_range(2, 20)));
        write_reg(REG_KEY_256, 64'($urandom_range(0, 1)));
    endtask

    row_t rows [$];
    row_t row;
    item_t fixed_it;

    initial begin
        int sent;
        cycles = 0; mismatches = 0; rx_stall_mode = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        aresetn = 1'b0;
        predict_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With all-zero 32-byte key, nonce and counter at 20
        // rounds the first keystream bytes are 76 b8 e0 ad a0 f1 3d 90.
        rows.push_back('{8'h00, 1'b0, 1'b1, 8'h76});
        rows.push_back('{8'hFF, 1'b0, 1'b1, 8'h47});
        rows.push_back('{8'h00, 1'b1, 1'b1, 8'he0});
        rows.push_back('{8'h0F, 1'b0, 1'b1, 8'ha2});
        rows.push_back('{8'hA5, 1'b1, 1'b0, 8'h00});
        rows.push_back('{8'h5A, 1'b0, 1'b0, 8'h00});
        foreach (rows[i]) begin
            row = rows[i];
            send_byte(row.data, row.last);
            if (row.fixed) begin
                fixed_it.data = row.want; fixed_it.last = row.last;
                expected_bytes[expected_bytes.size() - 1] = fixed_it;
            end
        end
        s_tvalid <= 1'b0;
        drain();

        // Extremes: odd round count, 16-byte key, counter wrap, two-round setting.
        write_reg(REG_ROUNDS, 64'd7);
        write_reg(REG_KEY_256, 64'd0);
        write_reg(REG_KEY_01, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KEY_23, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_CTR_NONCE, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 70; i++) send_byte(8'($urandom), i % 20 == 19);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_ROUNDS, 64'd2);
        write_reg(REG_KEY_256, 64'd1);
        write_reg(REG_NONCE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 10; i++) send_byte(8'($urandom), 1'b0);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_ROUNDS, 64'd20);

        // Random phases, each with fresh settings.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            random_config();
            for (int i = 0; i < 150 && sent < RANDOM_BYTES; i++) begin
                send_byte(8'($urandom), $urandom_range(0, 15) == 0);
                sent++;
                idle_gap();
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
